// ===== rtl/core/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants for the cache tag controller
// Set geometry, configuration record, queue entry and back-end state codes.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MAX_SETS    = 1024;
  localparam int SET_W       = $clog2(MAX_SETS);
  localparam int ADDR_W      = 32;
  localparam int TAG_W       = ADDR_W;
  localparam int CNT_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WB_ALLOC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS  = 2'd3;

  // access kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  typedef struct packed {
    logic [1:0] ways_in_use;
    logic       write_back_allocate;
    logic [4:0] offset_bits;
    logic [3:0] set_bits;
  } cfg_t;

  // one classified access waiting for the back end
  typedef struct packed {
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] blk;
    logic             store;
  } queue_entry_t;

  // per-set control bits held in the state memory
  typedef struct packed {
    logic       lru;
    logic [1:0] dirty;
    logic [1:0] valid;
  } set_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/salc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_front: access intake and address split
// Accepts an item, splits the address into block address and set index and
// classifies the access kind before it enters the queue.
// ----------------------------------------------------------------------------
module salc_front (
  input  salc_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             access_kind,
  input  logic [31:0]            address,
  input  logic                   q_full,
  input  logic                   clearing,
  output logic                   push,
  output salc_pkg::queue_entry_t push_entry
);
  import salc_pkg::*;

  logic [TAG_W-1:0] blk;
  logic [TAG_W-1:0] set_mask;
  logic [TAG_W-1:0] sfield;

  // no intake while the set memory is being cleared
  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  // address split: block address, then set field folded to the set count
  assign blk      = address >> cfg.offset_bits;
  assign set_mask = (TAG_W'(1) << cfg.set_bits) - TAG_W'(1);
  assign sfield   = blk & set_mask;

  assign push_entry.set_idx = sfield[SET_W-1:0];
  assign push_entry.blk     = blk;
  assign push_entry.store   = (access_kind == KIND_STORE);

endmodule
`default_nettype wire

// ===== rtl/core/salc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_queue: short queue between front and back end
// Holds classified items so that intake and lookup stall independently.
// ----------------------------------------------------------------------------
module salc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  salc_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output salc_pkg::queue_entry_t head_entry
);
  import salc_pkg::*;

  queue_entry_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/salc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_back: tag lookup, replacement and counters
// Reads the set, compares tags, picks the victim, writes the set back and
// loads the result register. Clears the set state memory after reset.
// ----------------------------------------------------------------------------
module salc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  salc_pkg::cfg_t         cfg,
  input  logic                   q_valid,
  input  salc_pkg::queue_entry_t q_entry,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   hit,
  output logic                   way_used,
  output logic                   memory_touched,
  output logic                   dirty_evicted,
  output logic [31:0]            hit_total,
  output logic [31:0]            miss_total,
  output logic [31:0]            memory_total
);
  import salc_pkg::*;

  // set memories: tags are never cleared, control bits are
  logic [TAG_W-1:0] tag0_mem [MAX_SETS];
  logic [TAG_W-1:0] tag1_mem [MAX_SETS];
  set_state_t       st_mem   [MAX_SETS];

  back_state_t      state, state_next;
  logic [SET_W-1:0] clr_idx;
  queue_entry_t     cur;
  logic [TAG_W-1:0] tag0_q, tag1_q;
  set_state_t       st_q;

  logic             rd_en;
  logic             commit;
  logic             st_we;
  logic [SET_W-1:0] st_waddr;
  set_state_t       st_wdata;
  logic             tag_we0, tag_we1;

  logic             two, wb;
  logic             hit0, hit1, is_hit, hit_way;
  logic             fill, victim, way_sel, mem_acc, devict;
  set_state_t       st_new;

  logic [CNT_W-1:0] hit_cnt, miss_cnt, mem_cnt;
  logic [CNT_W-1:0] hit_cnt_next, miss_cnt_next, mem_cnt_next;

  assign clearing = (state == BK_CLEAR);
  assign two      = cfg.ways_in_use[1];
  assign wb       = cfg.write_back_allocate;

  // tag compare; way 0 wins when both match
  assign hit0    = st_q.valid[0] && (tag0_q == cur.blk);
  assign hit1    = two && st_q.valid[1] && (tag1_q == cur.blk);
  assign is_hit  = hit0 || hit1;
  assign hit_way = !hit0;

  // write-through store misses do not fill
  assign fill = !is_hit && (wb || !cur.store);

  // victim: invalid way first, else the LRU way
  always_comb begin
    if (!st_q.valid[0]) begin
      victim = 1'b0;
    end else if (two && !st_q.valid[1]) begin
      victim = 1'b1;
    end else if (two) begin
      victim = st_q.lru;
    end else begin
      victim = 1'b0;
    end
  end

  assign way_sel = is_hit ? hit_way : (fill ? victim : 1'b0);
  assign mem_acc = is_hit ? (cur.store && !wb) : 1'b1;
  assign devict  = fill && st_q.valid[victim] && st_q.dirty[victim];

  // updated set control bits
  always_comb begin
    st_new = st_q;
    if (is_hit) begin
      if (two) begin
        st_new.lru = !hit_way;
      end
      if (cur.store && wb) begin
        st_new.dirty[hit_way] = 1'b1;
      end
    end else if (fill) begin
      st_new.valid[victim] = 1'b1;
      st_new.dirty[victim] = wb && cur.store;
      if (two) begin
        st_new.lru = !victim;
      end
    end
  end

  // saturating counters
  assign hit_cnt_next  = (is_hit && !(&hit_cnt)) ? hit_cnt + CNT_W'(1) : hit_cnt;
  assign miss_cnt_next = (!is_hit && !(&miss_cnt)) ? miss_cnt + CNT_W'(1) : miss_cnt;
  assign mem_cnt_next  = (mem_acc && !(&mem_cnt)) ? mem_cnt + CNT_W'(1) : mem_cnt;

  // sequencer: clear pass, fetch from queue, lookup and commit
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    q_pop      = 1'b0;
    commit     = 1'b0;
    st_we      = 1'b0;
    st_waddr   = cur.set_idx;
    st_wdata   = st_new;
    case (state)
      BK_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_idx;
        st_wdata = '0;
        if (clr_idx == SET_W'(MAX_SETS - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          st_we      = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign tag_we0 = commit && fill && !victim;
  assign tag_we1 = commit && fill && victim;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      mem_cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
      if (commit) begin
        out_valid <= 1'b1;
        hit_cnt   <= hit_cnt_next;
        miss_cnt  <= miss_cnt_next;
        mem_cnt   <= mem_cnt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // current item and result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
    if (commit) begin
      hit            <= is_hit;
      way_used       <= way_sel;
      memory_touched <= mem_acc;
      dirty_evicted  <= devict;
      hit_total      <= hit_cnt_next;
      miss_total     <= miss_cnt_next;
      memory_total   <= mem_cnt_next;
    end
  end

  // set memory reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag0_q <= tag0_mem[q_entry.set_idx];
      tag1_q <= tag1_mem[q_entry.set_idx];
      st_q   <= st_mem[q_entry.set_idx];
    end
  end

  // set memory writes
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (tag_we0) begin
      tag0_mem[cur.set_idx] <= cur.blk;
    end
    if (tag_we1) begin
      tag1_mem[cur.set_idx] <= cur.blk;
    end
  end

  // checks
  a_no_pop_outside_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_IDLE))
    else $error("queue popped outside idle");

  a_no_tag_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR) |-> (!tag_we0 && !tag_we1 && !commit))
    else $error("lookup activity during clear pass");

  a_single_way_fill: assert property (@(posedge clk) disable iff (rst)
    !(tag_we0 && tag_we1))
    else $error("both ways filled at once");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    commit && is_hit |-> !devict && !fill)
    else $error("hit caused a fill or eviction");

  a_lookup_follows_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == BK_LOOKUP))
    else $error("pop not followed by lookup");

endmodule
`default_nettype wire

// ===== rtl/core/set_assoc_cache_lru_tag_controller_core.sv =====
// Path: an accepted item is written into the queue, then read from the set
// memories into the read registers, then compared, written back and loaded
// into the result register. The back end finishes one item's write-back
// before it pops the next; the queue holds two items.
// Reset: synchronous; a clearing pass of all 1024 sets zeroes the valid, dirty
// and LRU bits, and no item is accepted until it ends. Counters reset to zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tag_controller_core: cache tag controller top level
// Configuration registers, access intake, queue and lookup back end.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tag_controller_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       access_kind,
  input  logic [31:0]                      address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic                             way_used,
  output logic                             memory_touched,
  output logic                             dirty_evicted,
  output logic [31:0]                      hit_total,
  output logic [31:0]                      miss_total,
  output logic [31:0]                      memory_total
);
  import salc_pkg::*;

  cfg_t         cfg;
  logic         push, q_full, q_pop, q_valid, clearing;
  queue_entry_t push_entry, head_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ways_in_use         <= 2'd1;
      cfg.write_back_allocate <= 1'b0;
      cfg.offset_bits         <= 5'd2;
      cfg.set_bits            <= 4'd8;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WAYS:     cfg.ways_in_use         <= cfg_data[1:0];
        CFG_WB_ALLOC: cfg.write_back_allocate <= cfg_data[0];
        CFG_OFFSET:   cfg.offset_bits         <= cfg_data[4:0];
        CFG_SET_BITS: cfg.set_bits            <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  salc_front u_front (
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .access_kind (access_kind),
    .address     (address),
    .q_full      (q_full),
    .clearing    (clearing),
    .push        (push),
    .push_entry  (push_entry)
  );

  salc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  salc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_entry        (head_entry),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way_used       (way_used),
    .memory_touched (memory_touched),
    .dirty_evicted  (dirty_evicted),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .memory_total   (memory_total)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: cache tag controller
// Sends loads, stores and fetches through the access channel under several
// cache geometries, both write policies and every associativity code. A local
// copy of the tag, valid, dirty and LRU state predicts each result item, and a
// checker compares every returned item, in order, against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import salc_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, behaves as a load
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic        hit;
    logic        way;
    logic        mem;
    logic        dirty_evict;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] mem_accesses;
  } access_result_t;

  // block inputs, all known from time zero
  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_WAYS;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic [1:0]            access_kind = KIND_LOAD;
  logic [31:0]           address     = '0;
  logic                  out_ready   = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic        hit;
  logic        way_used;
  logic        memory_touched;
  logic        dirty_evicted;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] memory_total;

  // idling controls
  bit   tx_idle_on  = 1'b1;
  logic rx_idle_on  = 1'b1;
  int   rx_stall    = 0;

  int fail_count = 0;

  // predicted cache state
  cfg_t        cache_cfg;
  logic [31:0] line_tag   [0:2*MAX_SETS-1];
  logic        line_valid [0:2*MAX_SETS-1];
  logic        line_dirty [0:2*MAX_SETS-1];
  logic        set_lru    [0:MAX_SETS-1];
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] mem_count;

  access_result_t expected_results[$];

  set_assoc_cache_lru_tag_controller_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .access_kind    (access_kind),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way_used       (way_used),
    .memory_touched (memory_touched),
    .dirty_evicted  (dirty_evicted),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .memory_total   (memory_total)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cache state prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  task automatic reset_model();
    int i;
    for (i = 0; i < 2 * MAX_SETS; i++) begin
      line_tag[i]   = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
    end
    for (i = 0; i < MAX_SETS; i++) set_lru[i] = 1'b0;
    hit_count  = '0;
    miss_count = '0;
    mem_count  = '0;
    cache_cfg  = '{ways_in_use: 2'd1, write_back_allocate: 1'b0,
                   offset_bits: 5'd2, set_bits: 4'd8};
  endtask

  function automatic access_result_t predict_access(input logic [1:0]  kind,
                                                    input logic [31:0] addr);
    access_result_t r;
    logic [31:0]    blk;
    logic [31:0]    set_field;
    int unsigned    set_no;
    int unsigned    slot;
    int             nways;
    int             hit_way;
    int             w;
    bit             two_way;
    bit             wb;
    bit             store;
    r         = '0;
    blk       = addr >> cache_cfg.offset_bits;
    set_field = blk & ((32'd1 << cache_cfg.set_bits) - 32'd1);
    set_no    = set_field % MAX_SETS;
    two_way   = (cache_cfg.ways_in_use >= 2'd2);
    wb        = cache_cfg.write_back_allocate;
    store     = (kind == KIND_STORE);
    nways     = two_way ? 2 : 1;
    hit_way   = -1;
    // way 0 wins when both ways hold the block
    for (w = nways - 1; w >= 0; w--)
      if (line_valid[set_no*2 + w] && line_tag[set_no*2 + w] == blk) hit_way = w;

    if (hit_way >= 0) begin
      slot      = set_no*2 + hit_way;
      r.hit     = 1'b1;
      r.way     = hit_way[0];
      hit_count = sat_inc(hit_count);
      if (two_way) set_lru[set_no] = ~r.way;
      if (store) begin
        if (wb) begin
          line_dirty[slot] = 1'b1;
        end else begin
          r.mem     = 1'b1;
          mem_count = sat_inc(mem_count);
        end
      end
    end else begin
      miss_count = sat_inc(miss_count);
      r.mem      = 1'b1;
      mem_count  = sat_inc(mem_count);
      // write-through stores bypass the cache on a miss
      if (wb || !store) begin
        if (!line_valid[set_no*2])                    r.way = 1'b0;
        else if (two_way && !line_valid[set_no*2 + 1]) r.way = 1'b1;
        else if (two_way)                             r.way = set_lru[set_no];
        else                                          r.way = 1'b0;
        slot             = set_no*2 + r.way;
        r.dirty_evict    = line_valid[slot] && line_dirty[slot];
        line_tag[slot]   = blk;
        line_valid[slot] = 1'b1;
        line_dirty[slot] = wb && store;
        if (two_way) set_lru[set_no] = ~r.way;
      end
    end
    r.hits         = hit_count;
    r.misses       = miss_count;
    r.mem_accesses = mem_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: back-pressure and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rx_idle_on) begin
      out_ready <= 1'b1;
      rx_stall  <= 0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_stall  <= $urandom_range(1, 3) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    access_result_t got;
    access_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {hit, way_used, memory_touched, dirty_evicted,
             hit_total, miss_total, memory_total};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected result item hit=%0d way=%0d", $realtime, hit, way_used);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch expected hit=%0d way=%0d mem=%0d dev=%0d h=%0d m=%0d t=%0d",
                     $realtime, want.hit, want.way, want.mem, want.dirty_evict,
                     want.hits, want.misses, want.mem_accesses);
            $display("%0t:          actual   hit=%0d way=%0d mem=%0d dev=%0d h=%0d m=%0d t=%0d",
                     $realtime, got.hit, got.way, got.mem, got.dirty_evict,
                     got.hits, got.misses, got.mem_accesses);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Access side and configuration
  // ---------------------------------------------------------------------------
  // valid is left high on return; the next call either replaces the item
  // or lowers valid in the same step
  task automatic send_access(input logic [1:0] kind, input logic [31:0] addr);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    access_kind <= kind;
    address     <= addr;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_access(kind, addr));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_idle();
    int waited;
    waited   = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0t: %0d result items never arrived", $realtime, expected_results.size());
      expected_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // writes all four registers; spare data bits above the ways, policy and set-count fields carry junk
  task automatic apply_config(input logic [1:0] ways, input logic wb,
                              input logic [4:0] off, input logic [3:0] sets,
                              input logic [4:0] junk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WAYS;
    cfg_data  <= {junk[4:2], ways};
    @(posedge clk);
    cfg_index <= CFG_WB_ALLOC;
    cfg_data  <= {junk[4:1], wb};
    @(posedge clk);
    cfg_index <= CFG_OFFSET;
    cfg_data  <= off;
    @(posedge clk);
    cfg_index <= CFG_SET_BITS;
    cfg_data  <= {junk[4], sets};
    @(posedge clk);
    cfg_write <= 1'b0;
    cache_cfg = '{ways_in_use: ways, write_back_allocate: wb,
                  offset_bits: off, set_bits: sets};
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // direct mapped, write-through: hits, store bypass, conflicts, address ends
  task automatic test_direct_mapped();
    wait_idle();
    apply_config(2'd1, 1'b0, 5'd2, 4'd8, 5'd0);
    send_access(KIND_LOAD,  32'h0000_0000);
    send_access(KIND_LOAD,  32'h0000_0003);
    send_access(KIND_STORE, 32'h0000_0000);
    send_access(KIND_STORE, 32'h0000_1000);
    send_access(KIND_FETCH, 32'h0000_1000);
    send_access(KIND_SPARE, 32'h0000_1000);
    send_access(KIND_LOAD,  32'hFFFF_FFFF);
    send_access(KIND_FETCH, 32'hFFFF_FFFC);
  endtask

  // two-way write-back: LRU victim choice and dirty eviction in one set
  task automatic test_two_way_write_back();
    wait_idle();
    apply_config(2'd2, 1'b1, 5'd4, 4'd3, 5'd0);
    send_access(KIND_STORE, 32'h0000_0010);
    send_access(KIND_LOAD,  32'h0000_0090);
    send_access(KIND_LOAD,  32'h0000_0010);
    send_access(KIND_LOAD,  32'h0000_0110);
    send_access(KIND_LOAD,  32'h0000_0090);
    send_access(KIND_STORE, 32'h0000_0110);
  endtask

  // associativity codes 0 and 3, widest offset, set index past the set count
  task automatic test_odd_associativity();
    wait_idle();
    apply_config(2'd0, 1'b1, 5'd0, 4'd0, 5'd0);
    send_access(KIND_STORE, 32'h0000_0005);
    send_access(KIND_LOAD,  32'h0000_0006);
    wait_idle();
    apply_config(2'd3, 1'b0, 5'd16, 4'd15, 5'd0);
    send_access(KIND_LOAD,  32'hFFFF_0000);
    send_access(KIND_LOAD,  32'h03FF_0000);
    send_access(KIND_FETCH, 32'hFFFF_1234);
    wait_idle();
    apply_config(2'd2, 1'b1, 5'd31, 4'd10, 5'd0);
    send_access(KIND_STORE, 32'h8000_0000);
    send_access(KIND_LOAD,  32'h7FFF_FFFF);
  endtask

  // same block left in both ways after a switch to direct mapped and back
  task automatic test_duplicate_lines();
    wait_idle();
    apply_config(2'd2, 1'b0, 5'd4, 4'd3, 5'd0);
    send_access(KIND_LOAD, 32'h0000_0010);
    send_access(KIND_LOAD, 32'h0000_0090);
    wait_idle();
    apply_config(2'd1, 1'b0, 5'd4, 4'd3, 5'd0);
    send_access(KIND_LOAD, 32'h0000_0090);
    wait_idle();
    apply_config(2'd2, 1'b0, 5'd4, 4'd3, 5'd0);
    send_access(KIND_LOAD, 32'h0000_0090);
  endtask

  // phases of random traffic; most addresses come from a small pool of
  // conflicting blocks so that hits, victims and dirty lines all recur
  task automatic test_random_traffic();
    logic [1:0]  ways;
    logic        wb;
    logic [4:0]  off;
    logic [3:0]  sets;
    logic [31:0] pool_set [0:3];
    logic [31:0] pool_tag [0:2];
    logic [63:0] a;
    logic [31:0] addr;
    logic [1:0]  kind;
    int          p;
    int          i;
    int          pick;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin ways = 2'd1; wb = 1'b0; off = 5'd0;  sets = 4'd0;  end
        1: begin ways = 2'd2; wb = 1'b1; off = 5'd16; sets = 4'd10; end
        2: begin ways = 2'd3; wb = 1'b1; off = 5'd31; sets = 4'd15; end
        3: begin ways = 2'd0; wb = 1'b0; off = 5'd2;  sets = 4'd8;  end
        default: begin
          ways = 2'($urandom_range(0, 3));
          wb   = 1'($urandom_range(0, 1));
          off  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, 6));
          sets = 4'($urandom_range(0, 15));
        end
      endcase
      wait_idle();
      apply_config(ways, wb, off, sets, 5'($urandom_range(0, 31)));
      for (i = 0; i < 4; i++) pool_set[i] = $urandom;
      for (i = 0; i < 3; i++) pool_tag[i] = $urandom;

      for (i = 0; i < PHASE_ITEMS; i++) begin
        // the last phase runs without idling on either side
        if (i % 40 == 0) begin
          tx_idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
          rx_idle_on <= (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        if (i == PHASE_ITEMS / 2 && p[0]) wait_idle();

        pick = $urandom_range(0, 9);
        if (pick < 4)      kind = KIND_LOAD;
        else if (pick < 7) kind = KIND_STORE;
        else if (pick < 9) kind = KIND_FETCH;
        else               kind = KIND_SPARE;

        if ($urandom_range(0, 4) == 0) begin
          addr = $urandom;
        end else begin
          a = ({32'd0, pool_tag[$urandom_range(0, 2)]} << (int'(off) + int'(sets)))
            | (({32'd0, pool_set[$urandom_range(0, 3)]} & ((64'd1 << sets) - 64'd1)) << off)
            | ({32'd0, $urandom} & ((64'd1 << off) - 64'd1));
          addr = a[31:0];
        end
        send_access(kind, addr);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_direct_mapped();
    test_two_way_write_back();
    test_odd_associativity();
    test_duplicate_lines();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit, well past the slowest correct run
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
